// ----- hdl/rsaeps_pkg.sv -----
// rsaeps_pkg: shared command and status types for the exponent pair search
// used by rsaeps_ctrl, rsaeps_dp and the top level; no dependencies
package rsaeps_pkg;

    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_LOAD     = 4'd1,
        OP_GCD_INIT = 4'd2,
        OP_DIV_INIT = 4'd3,
        OP_DIV_STEP = 4'd4,
        OP_GCD_NEXT = 4'd5,
        OP_E_INC    = 4'd6,
        OP_INV_INIT = 4'd7,
        OP_INV_NEXT = 4'd8,
        OP_FIX_MOD  = 4'd9,
        OP_FIX_SIGN = 4'd10,
        OP_EMIT     = 4'd11
    } op_t;

    typedef struct packed {
        op_t  op;
        logic degen;
    } cmd_t;

    typedef struct packed {
        logic phi_small;
        logic b_zero;
        logic a_one;
    } sts_t;

    localparam int unsigned FIELD_W = 32;

endpackage

// ----- hdl/rsaeps_dp.sv -----
// rsaeps_dp: datapath with euclid registers, shift-subtract divider and
// quotient-times-coefficient accumulator; depends on rsaeps_pkg
module rsaeps_dp #(
    parameter int unsigned WIDTH = 32
) (
    input  logic                          clk,
    input  rsaeps_pkg::cmd_t              cmd,
    output rsaeps_pkg::sts_t              sts,
    input  logic [rsaeps_pkg::FIELD_W-1:0] totient,
    output logic [rsaeps_pkg::FIELD_W-1:0] public_exponent,
    output logic [rsaeps_pkg::FIELD_W-1:0] private_exponent,
    output logic                          degenerate
);
    localparam int unsigned FW = rsaeps_pkg::FIELD_W;

    logic [WIDTH-1:0] phi_reg, e_reg, a_reg, b_reg, dvd_reg, rem_reg;
    logic [WIDTH-1:0] prev_reg, cur_reg, acc_reg, d_reg;
    logic             prev_neg_reg, cur_neg_reg;
    logic [FW-1:0]    pub_reg, priv_reg;
    logic             degen_reg;

    logic [WIDTH+FW-1:0] tot_ext, e_ext, d_ext;
    logic [WIDTH-1:0]    phi_in, e_inc, pm;
    logic [WIDTH:0]      rem_sh;
    logic [WIDTH+1:0]    diff;
    logic                ge;
    logic [WIDTH-1:0]    acc_add, pm_diff;
    logic [WIDTH:0]      mod_diff;

    assign tot_ext = {{WIDTH{1'b0}}, totient};
    assign phi_in  = tot_ext[WIDTH-1:0];
    assign e_inc   = e_reg + WIDTH'(1);

    // one restoring division step
    assign rem_sh  = {rem_reg, dvd_reg[WIDTH-1]};
    assign diff    = {1'b0, rem_sh} - {2'b00, b_reg};
    assign ge      = ~diff[WIDTH+1];
    assign acc_add = {acc_reg[WIDTH-2:0], 1'b0} + (ge ? cur_reg : '0);

    // coefficient reduction and sign fix
    assign mod_diff = {1'b0, prev_reg} - {1'b0, phi_reg};
    assign pm       = mod_diff[WIDTH] ? prev_reg : mod_diff[WIDTH-1:0];
    assign pm_diff  = phi_reg - prev_reg;

    assign e_ext = {{FW{1'b0}}, e_reg};
    assign d_ext = {{FW{1'b0}}, d_reg};

    always_ff @(posedge clk) begin
        unique case (cmd.op)
            rsaeps_pkg::OP_LOAD: phi_reg <= phi_in;
            rsaeps_pkg::OP_GCD_INIT:
            begin
                e_reg <= WIDTH'(2);
                a_reg <= phi_reg;
                b_reg <= WIDTH'(2);
            end
            rsaeps_pkg::OP_E_INC:
            begin
                e_reg <= e_inc;
                a_reg <= phi_reg;
                b_reg <= e_inc;
            end
            rsaeps_pkg::OP_DIV_INIT:
            begin
                dvd_reg <= a_reg;
                rem_reg <= '0;
                acc_reg <= '0;
            end
            rsaeps_pkg::OP_DIV_STEP:
            begin
                dvd_reg <= {dvd_reg[WIDTH-2:0], 1'b0};
                rem_reg <= ge ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
                acc_reg <= acc_add;
            end
            rsaeps_pkg::OP_GCD_NEXT:
            begin
                a_reg <= b_reg;
                b_reg <= rem_reg;
            end
            rsaeps_pkg::OP_INV_INIT:
            begin
                a_reg        <= phi_reg;
                b_reg        <= e_reg;
                prev_reg     <= '0;
                cur_reg      <= WIDTH'(1);
                prev_neg_reg <= 1'b0;
                cur_neg_reg  <= 1'b0;
            end
            rsaeps_pkg::OP_INV_NEXT:
            begin
                a_reg        <= b_reg;
                b_reg        <= rem_reg;
                prev_reg     <= cur_reg;
                cur_reg      <= prev_reg + acc_reg;
                prev_neg_reg <= cur_neg_reg;
                cur_neg_reg  <= ~cur_neg_reg;
            end
            rsaeps_pkg::OP_FIX_MOD: prev_reg <= pm;
            rsaeps_pkg::OP_FIX_SIGN:
                d_reg <= (prev_neg_reg && prev_reg != '0) ? pm_diff : prev_reg;
            rsaeps_pkg::OP_EMIT:
            begin
                pub_reg   <= cmd.degen ? '0 : e_ext[FW-1:0];
                priv_reg  <= cmd.degen ? '0 : d_ext[FW-1:0];
                degen_reg <= cmd.degen;
            end
            default: ;
        endcase
    end

    assign sts.phi_small = phi_reg < WIDTH'(3);
    assign sts.b_zero    = b_reg == '0;
    assign sts.a_one     = a_reg == WIDTH'(1);

    assign public_exponent  = pub_reg;
    assign private_exponent = priv_reg;
    assign degenerate       = degen_reg;
endmodule

// ----- hdl/rsaeps_ctrl.sv -----
// rsaeps_ctrl: sequencer for search, gcd and inverse phases plus handshakes
// depends on rsaeps_pkg
module rsaeps_ctrl #(
    parameter int unsigned WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  rsaeps_pkg::sts_t sts,
    output rsaeps_pkg::cmd_t cmd
);
    localparam int unsigned CW = $clog2(WIDTH);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_CHECK    = 13'b0000000000010,
        S_DIV_INIT = 13'b0000000000100,
        S_DIV_STEP = 13'b0000000001000,
        S_GCD_NEXT = 13'b0000000010000,
        S_GCD_TEST = 13'b0000000100000,
        S_E_INC    = 13'b0000001000000,
        S_INV_INIT = 13'b0000010000000,
        S_INV_NEXT = 13'b0000100000000,
        S_INV_TEST = 13'b0001000000000,
        S_FIX_MOD  = 13'b0010000000000,
        S_FIX_SIGN = 13'b0100000000000,
        S_EMIT     = 13'b1000000000000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          inv_reg, inv_next;
    logic          degen_reg, degen_next;
    logic          out_valid_reg, out_valid_next;
    logic          emit;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        inv_next   = inv_reg;
        degen_next = degen_reg;
        cmd.op     = rsaeps_pkg::OP_NONE;
        cmd.degen  = degen_reg;
        emit       = 1'b0;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.op     = rsaeps_pkg::OP_LOAD;
                    state_next = S_CHECK;
                end
            S_CHECK:
            begin
                inv_next = 1'b0;
                if (sts.phi_small)
                begin
                    degen_next = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    degen_next = 1'b0;
                    cmd.op     = rsaeps_pkg::OP_GCD_INIT;
                    state_next = S_DIV_INIT;
                end
            end
            S_DIV_INIT:
            begin
                cmd.op     = rsaeps_pkg::OP_DIV_INIT;
                cnt_next   = '0;
                state_next = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                cmd.op   = rsaeps_pkg::OP_DIV_STEP;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(WIDTH - 1))
                    state_next = inv_reg ? S_INV_NEXT : S_GCD_NEXT;
            end
            S_GCD_NEXT:
            begin
                cmd.op     = rsaeps_pkg::OP_GCD_NEXT;
                state_next = S_GCD_TEST;
            end
            S_GCD_TEST:
                priority if (!sts.b_zero) state_next = S_DIV_INIT;
                else if (sts.a_one)       state_next = S_INV_INIT;
                else                      state_next = S_E_INC;
            S_E_INC:
            begin
                cmd.op     = rsaeps_pkg::OP_E_INC;
                state_next = S_DIV_INIT;
            end
            S_INV_INIT:
            begin
                cmd.op     = rsaeps_pkg::OP_INV_INIT;
                inv_next   = 1'b1;
                state_next = S_DIV_INIT;
            end
            S_INV_NEXT:
            begin
                cmd.op     = rsaeps_pkg::OP_INV_NEXT;
                state_next = S_INV_TEST;
            end
            S_INV_TEST:
                state_next = sts.b_zero ? S_FIX_MOD : S_DIV_INIT;
            S_FIX_MOD:
            begin
                cmd.op     = rsaeps_pkg::OP_FIX_MOD;
                state_next = S_FIX_SIGN;
            end
            S_FIX_SIGN:
            begin
                cmd.op     = rsaeps_pkg::OP_FIX_SIGN;
                state_next = S_EMIT;
            end
            S_EMIT:
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op     = rsaeps_pkg::OP_EMIT;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        priority if (emit)                      out_valid_next = 1'b1;
        else if (out_valid_reg && out_ready)    out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            inv_reg       <= 1'b0;
            degen_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            inv_reg       <= inv_next;
            degen_reg     <= degen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
endmodule

// ----- hdl/rsa_exponent_pair_search.sv -----
// rsa_exponent_pair_search: top level joining rsaeps_ctrl and rsaeps_dp
// depends on rsaeps_pkg, rsaeps_ctrl, rsaeps_dp
//
// channel  signals                                        dir
// in       in_valid/in_ready, totient                     beat in
// out      out_valid/out_ready, public_exponent,          beat out
//          private_exponent, degenerate
//
// one beat at a time; the shift-subtract divider runs WIDTH divide steps per
// euclid step, plus the DIV_INIT, NEXT and TEST states around each step
// a totient below 3 goes straight to emit with degenerate set
// reset clears only control state; no clearing pass
// the result waits in the output register while the next beat is taken
module rsa_exponent_pair_search #(
    parameter int unsigned WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] totient,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] public_exponent,
    output logic [31:0] private_exponent,
    output logic        degenerate
);
    rsaeps_pkg::cmd_t cmd;   // controller to datapath
    rsaeps_pkg::sts_t sts;   // datapath flags back

    // sequencer: search for e, gcd test, extended euclid, fixup, emit
    rsaeps_ctrl #(.WIDTH(WIDTH)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // registers, divider and output payload
    rsaeps_dp #(.WIDTH(WIDTH)) u_dp (
        .clk              (clk),
        .cmd              (cmd),
        .sts              (sts),
        .totient          (totient),
        .public_exponent  (public_exponent),
        .private_exponent (private_exponent),
        .degenerate       (degenerate)
    );
endmodule

// ----- hdl/rsaeps_checker.sv -----
// rsaeps_checker: port-level assertions for rsa_exponent_pair_search
// bound to the top level below; no package dependencies
module rsaeps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] public_exponent,
    input logic [31:0] private_exponent,
    input logic        degenerate
);
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> public_exponent == 32'd0 && private_exponent == 32'd0)
        else $error("degenerate result with nonzero exponent");

    a_pub_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate |-> public_exponent >= 32'd2)
        else $error("public exponent below two");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a beat while busy");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(public_exponent)
            && $stable(private_exponent))
        else $error("stalled result changed");
endmodule

bind rsa_exponent_pair_search rsaeps_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .public_exponent  (public_exponent),
    .private_exponent (private_exponent),
    .degenerate       (degenerate)
);
